>>> hdl/htp_pkg.sv
// Package: shared constants, codes and types of the request-target parser.
`timescale 1ns / 1ps
package htp_pkg;

	localparam int NAME_CAPACITY = 128;
	localparam int CNT_W = $clog2(NAME_CAPACITY);
	localparam int LEN_W = 7;
	localparam int SAT_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(NAME_CAPACITY - 1);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
	localparam logic [SAT_W-1:0] LEN_MAX = SAT_W'((1 << LEN_W) - 1);

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	localparam logic [1:0] PH_METHOD = 2'd0;
	localparam logic [1:0] PH_SPACES = 2'd1;
	localparam logic [1:0] PH_PATH = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	localparam logic [1:0] V_ROOT = 2'd0;
	localparam logic [1:0] V_FILE = 2'd1;
	localparam logic [1:0] V_UNSAFE = 2'd2;
	localparam logic [1:0] V_MALFORMED = 2'd3;

	typedef struct packed {
		logic [1:0] phase;
		logic prev_dot;
		logic unsafe_seen;
		logic [CNT_W-1:0] count;
	} parse_state_t;

	typedef struct packed {
		logic path_valid;
		logic [7:0] path_char;
		logic verdict_valid;
		logic [1:0] verdict;
		logic [LEN_W-1:0] path_length;
		logic request_end;
	} parse_result_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_METHOD, prev_dot: 1'b0, unsafe_seen: 1'b0, count: '0
	};

endpackage

>>> hdl/htp_if.sv
// Interfaces: request byte channel and parse result channel.
`timescale 1ns / 1ps
interface htp_req_if;
	logic valid;
	logic ready;
	logic [7:0] request_byte;
	logic last_byte;

	modport source(output valid, request_byte, last_byte, input ready);
	modport sink(input valid, request_byte, last_byte, output ready);
endinterface

interface htp_res_if;
	logic valid;
	logic ready;
	logic path_valid;
	logic [7:0] path_char;
	logic verdict_valid;
	logic [1:0] verdict;
	logic [6:0] path_length;
	logic request_end;

	modport source(output valid, path_valid, path_char, verdict_valid, verdict,
		path_length, request_end, input ready);
	modport sink(input valid, path_valid, path_char, verdict_valid, verdict,
		path_length, request_end, output ready);
endinterface

>>> hdl/http_request_target_parse_unit.sv
// Top level: input stage, parse core and result register of the request-target parser.
// Flow: an accepted byte waits in the input stage; its core result loads the result register.
// Throughput: one request byte per cycle while results drain; a waiting result stalls a full
// input stage, which advances whenever the result register can take data.
// Reset: arst_n clears the valid flags and the parse state (method phase, count zero).
`timescale 1ns / 1ps
module http_request_target_parse_unit
	import htp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	htp_req_if.sink    req,
	htp_res_if.source  res
);

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// result register
	logic          res_valid_q;
	parse_result_t res_q;

	parse_result_t core_res;
	logic          out_free;
	logic          advance;

	// advance when the result register is empty or being drained this cycle
	assign out_free = !res_valid_q || res.ready;
	assign advance = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// hold the payload while stalled; load on every accepted request
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			byte_s1 <= req.request_byte;
			last_s1 <= req.last_byte;
		end
	end

	htp_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.request_byte (byte_s1),
		.last_byte    (last_s1),
		.result       (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= core_res;
		end
	end

	assign res.valid = res_valid_q;
	assign res.path_valid = res_q.path_valid;
	assign res.path_char = res_q.path_char;
	assign res.verdict_valid = res_q.verdict_valid;
	assign res.verdict = res_q.verdict;
	assign res.path_length = res_q.path_length;
	assign res.request_end = res_q.request_end;

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !out_free |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("input stage lost a stalled request");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("result register not loaded");

	a_path_counted: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.path_valid |-> res_q.path_length != '0)
		else $error("path character with zero length");

endmodule

>>> hdl/htp_core.sv
// Parse core: per-request state registers and the single-byte step logic.
`timescale 1ns / 1ps
module htp_core
	import htp_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic [7:0]    request_byte,
	input  logic          last_byte,
	output parse_result_t result
);

	parse_state_t st_q;
	parse_state_t st_nx;
	parse_result_t res;
	logic do_copy;
	logic end_path;
	logic malformed;
	logic [CNT_W-1:0] cnt_inc;
	logic [1:0] path_verdict;
	logic [SAT_W-1:0] cnt_ext;

	assign cnt_inc = st_q.count + CNT_ONE;

	always_comb begin
		st_nx = st_q;
		do_copy = 1'b0;
		end_path = 1'b0;
		malformed = 1'b0;
		case (st_q.phase)
			PH_METHOD: begin
				if (request_byte == CH_NUL) begin
					malformed = 1'b1;
				end else if (request_byte == CH_SPACE) begin
					st_nx.phase = PH_SPACES;
				end
			end
			PH_SPACES: begin
				if (request_byte == CH_SLASH) begin
					st_nx.phase = PH_PATH;
					st_nx.prev_dot = 1'b0;
					do_copy = 1'b1;
				end else if (request_byte != CH_SPACE) begin
					malformed = 1'b1;
				end
			end
			PH_PATH: begin
				if (request_byte inside {CH_NUL, CH_SPACE, CH_QUEST, CH_CR, CH_LF}) begin
					end_path = 1'b1;
				end else begin
					if (request_byte == CH_SLASH || request_byte == CH_BSLASH ||
						(request_byte == CH_DOT && st_q.prev_dot)) begin
						st_nx.unsafe_seen = 1'b1;
					end
					st_nx.prev_dot = (request_byte == CH_DOT);
					do_copy = 1'b1;
				end
			end
			default: begin
			end
		endcase

		if (do_copy) begin
			st_nx.count = cnt_inc;
			if (cnt_inc >= CNT_LIMIT) begin
				end_path = 1'b1;
			end
		end

		// final byte closes whatever is still open
		if (last_byte && !malformed && !end_path) begin
			if (st_nx.phase == PH_PATH) begin
				end_path = 1'b1;
			end else if (st_nx.phase != PH_DONE) begin
				malformed = 1'b1;
			end
		end

		if (st_nx.count == CNT_ONE) begin
			path_verdict = V_ROOT;
		end else if (st_nx.unsafe_seen) begin
			path_verdict = V_UNSAFE;
		end else begin
			path_verdict = V_FILE;
		end

		cnt_ext = SAT_W'(st_nx.count);

		res.path_valid = do_copy;
		res.path_char = do_copy ? request_byte : 8'h00;
		res.verdict_valid = malformed | end_path;
		res.verdict = malformed ? V_MALFORMED : (end_path ? path_verdict : V_ROOT);
		res.path_length = (cnt_ext > LEN_MAX) ? LEN_MAX[LEN_W-1:0] : cnt_ext[LEN_W-1:0];
		res.request_end = last_byte;

		if (malformed || end_path) begin
			st_nx.phase = PH_DONE;
		end
		if (last_byte) begin
			st_nx = STATE_RESET;
		end
	end

	assign result = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (advance) begin
			st_q <= st_nx;
		end
	end

	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_DONE |-> !res.path_valid && !res.verdict_valid)
		else $error("output after verdict");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.count <= CNT_LIMIT)
		else $error("copy count beyond limit");

	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_byte |=> st_q.phase == PH_METHOD && st_q.count == '0)
		else $error("state not cleared after final byte");

	a_verdict_done: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.verdict_valid && !last_byte |=> st_q.phase == PH_DONE)
		else $error("verdict without entering done phase");

endmodule
